### hw/rtl/sqf_pkg.sv
// ----------------------------------------------------------------------------
// Shifted quadratic fit package
// Shared types, constants and the solve program of the per-side fit lanes.
// ----------------------------------------------------------------------------
package sqf_pkg;

  localparam int FIT_TERMS  = 3;
  localparam int NPOW       = 2 * FIT_TERMS - 1;
  localparam int WIDE_W     = 256;
  localparam int LIMB_W     = 32;
  localparam int PROG_LEN   = 27;
  localparam int DET_LAST   = 14;
  localparam int NUM_WREGS  = 9;
  localparam int NUM_NREGS  = 11;
  localparam int FIT_W      = 32;

  typedef logic [WIDE_W-1:0] wide_t;

  // Wide working registers of the solver: cofactors, determinant, partial
  // Cramer sum and numerator.
  typedef enum logic [3:0] {
    W_C00, W_C01, W_C02, W_C11, W_C12, W_C22, W_DET, W_W, W_NUM
  } wreg_t;

  // 64-bit operands: power sums, cross sums and powers of the target.
  typedef enum logic [3:0] {
    N_S0, N_S1, N_S2, N_S3, N_S4, N_C0, N_C1, N_C2, N_T0, N_T1, N_T2
  } nreg_t;

  typedef struct packed {
    logic  a_wide;
    wreg_t a_w;
    nreg_t a_n;
    nreg_t b_n;
    wreg_t dst;
    logic  clr;
    logic  sub;
  } mac_op_t;

  typedef struct packed {
    logic [NPOW-1:0][63:0]      pw;
    logic [FIT_TERMS-1:0][63:0] cr;
  } sums_t;

  typedef struct packed {
    logic             idle;
    logic             done;
    logic             singular;
    logic [FIT_W-1:0] fit;
  } lane_stat_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LDA, S_LDB, S_MUL, S_DRAIN, S_WR, S_CHECK,
    S_DIV0, S_DIV1, S_DIV2, S_DIV, S_FIN, S_DONE
  } slv_state_t;

  function automatic mac_op_t op_nn(input nreg_t a, input nreg_t b, input wreg_t d,
                                    input logic clr, input logic sub);
    mac_op_t o;
    o.a_wide = 1'b0;
    o.a_w    = W_C00;
    o.a_n    = a;
    o.b_n    = b;
    o.dst    = d;
    o.clr    = clr;
    o.sub    = sub;
    return o;
  endfunction

  function automatic mac_op_t op_wn(input wreg_t a, input nreg_t b, input wreg_t d,
                                    input logic clr);
    mac_op_t o;
    o.a_wide = 1'b1;
    o.a_w    = a;
    o.a_n    = N_S0;
    o.b_n    = b;
    o.dst    = d;
    o.clr    = clr;
    o.sub    = 1'b0;
    return o;
  endfunction

  // Cofactors of the symmetric normal matrix, its determinant along row 0,
  // then for each power of the target the Cramer numerator column sum.
  function automatic mac_op_t prog_step(input logic [4:0] idx);
    mac_op_t o;
    case (idx)
      5'd0:    o = op_nn(N_S2, N_S4, W_C00, 1'b1, 1'b0);
      5'd1:    o = op_nn(N_S3, N_S3, W_C00, 1'b0, 1'b1);
      5'd2:    o = op_nn(N_S2, N_S3, W_C01, 1'b1, 1'b0);
      5'd3:    o = op_nn(N_S1, N_S4, W_C01, 1'b0, 1'b1);
      5'd4:    o = op_nn(N_S1, N_S3, W_C02, 1'b1, 1'b0);
      5'd5:    o = op_nn(N_S2, N_S2, W_C02, 1'b0, 1'b1);
      5'd6:    o = op_nn(N_S0, N_S4, W_C11, 1'b1, 1'b0);
      5'd7:    o = op_nn(N_S2, N_S2, W_C11, 1'b0, 1'b1);
      5'd8:    o = op_nn(N_S1, N_S2, W_C12, 1'b1, 1'b0);
      5'd9:    o = op_nn(N_S0, N_S3, W_C12, 1'b0, 1'b1);
      5'd10:   o = op_nn(N_S0, N_S2, W_C22, 1'b1, 1'b0);
      5'd11:   o = op_nn(N_S1, N_S1, W_C22, 1'b0, 1'b1);
      5'd12:   o = op_wn(W_C00, N_S0, W_DET, 1'b1);
      5'd13:   o = op_wn(W_C01, N_S1, W_DET, 1'b0);
      5'd14:   o = op_wn(W_C02, N_S2, W_DET, 1'b0);
      5'd15:   o = op_wn(W_C00, N_C0, W_W, 1'b1);
      5'd16:   o = op_wn(W_C01, N_C1, W_W, 1'b0);
      5'd17:   o = op_wn(W_C02, N_C2, W_W, 1'b0);
      5'd18:   o = op_wn(W_W, N_T0, W_NUM, 1'b1);
      5'd19:   o = op_wn(W_C01, N_C0, W_W, 1'b1);
      5'd20:   o = op_wn(W_C11, N_C1, W_W, 1'b0);
      5'd21:   o = op_wn(W_C12, N_C2, W_W, 1'b0);
      5'd22:   o = op_wn(W_W, N_T1, W_NUM, 1'b0);
      5'd23:   o = op_wn(W_C02, N_C0, W_W, 1'b1);
      5'd24:   o = op_wn(W_C12, N_C1, W_W, 1'b0);
      5'd25:   o = op_wn(W_C22, N_C2, W_W, 1'b0);
      5'd26:   o = op_wn(W_W, N_T2, W_NUM, 1'b0);
      default: o = op_nn(N_S0, N_S0, W_C00, 1'b1, 1'b0);
    endcase
    return o;
  endfunction

endpackage

### hw/rtl/sqf_accum.sv
// ----------------------------------------------------------------------------
// Shifted quadratic fit lane accumulator
// Clamps one abscissa, forms its powers and cross products in a short
// multiplier pipeline and adds them into the power and cross sums.
// ----------------------------------------------------------------------------
module sqf_accum (
  input  logic                clk,
  input  logic                rst,
  input  logic                smp_add,
  input  logic                smp_last,
  input  logic signed [16:0]  abscissa,
  input  logic        [15:0]  value,
  input  logic                clear,
  output sqf_pkg::sums_t      sums,
  output logic                sums_ready
);
  import sqf_pkg::*;

  logic               add1, last1, add2, last2, add3, last3;
  logic signed [15:0] x1, x2, x3;
  logic        [15:0] y1, y2, y3;
  logic signed [31:0] xsq2, xsq3;
  logic signed [32:0] xy2, xy3;
  logic signed [47:0] xcube3, yxsq3;
  logic signed [63:0] xquad3;
  logic        [63:0] quad_sum;
  logic signed [15:0] x_clamp;

  always_comb begin
    if (abscissa > 17'sd32767) begin
      x_clamp = 16'sh7FFF;
    end else if (abscissa < -17'sd32768) begin
      x_clamp = -16'sh8000;
    end else begin
      x_clamp = abscissa[15:0];
    end
  end

  assign quad_sum = sums.pw[4] + xquad3;

  always_ff @(posedge clk) begin
    if (rst) begin
      add1 <= 1'b0; last1 <= 1'b0;
      add2 <= 1'b0; last2 <= 1'b0;
      add3 <= 1'b0; last3 <= 1'b0;
    end else begin
      add1 <= smp_add; last1 <= smp_last;
      add2 <= add1;    last2 <= last1;
      add3 <= add2;    last3 <= last2;
    end
  end

  always_ff @(posedge clk) begin
    x1     <= x_clamp;
    y1     <= value;
    x2     <= x1;
    y2     <= y1;
    xsq2   <= x1 * x1;
    xy2    <= x1 * $signed({1'b0, y1});
    x3     <= x2;
    y3     <= y2;
    xsq3   <= xsq2;
    xy3    <= xy2;
    xcube3 <= xsq2 * x2;
    xquad3 <= xsq2 * xsq2;
    yxsq3  <= $signed({1'b0, y2}) * xsq2;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      sums       <= '0;
      sums_ready <= 1'b0;
    end else begin
      if (add3) begin
        sums.pw[0] <= sums.pw[0] + 64'd1;
        sums.pw[1] <= sums.pw[1] + {{48{x3[15]}}, x3};
        sums.pw[2] <= sums.pw[2] + {32'd0, xsq3};
        sums.pw[3] <= sums.pw[3] + {{16{xcube3[47]}}, xcube3};
        // Only the fourth power can run past the signed 64-bit range.
        sums.pw[4] <= quad_sum[63] ? 64'h7FFF_FFFF_FFFF_FFFF : quad_sum;
        sums.cr[0] <= sums.cr[0] + {48'd0, y3};
        sums.cr[1] <= sums.cr[1] + {{31{xy3[32]}}, xy3};
        sums.cr[2] <= sums.cr[2] + {{16{yxsq3[47]}}, yxsq3};
      end
      if (last3) begin
        sums_ready <= 1'b1;
      end
    end
  end

endmodule

### hw/rtl/sqf_solver.sv
// ----------------------------------------------------------------------------
// Shifted quadratic fit lane solver
// Exact cofactor solve of the 3x3 normal equations on a shared 32x32
// multiplier, then a restoring divide to a rounded, saturated Q24.8 value.
// ----------------------------------------------------------------------------
module sqf_solver (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  run,
  input  sqf_pkg::sums_t        sums,
  input  logic signed [15:0]    target,
  input  logic                  take,
  output sqf_pkg::lane_stat_t   stat
);
  import sqf_pkg::*;

  slv_state_t       state, state_next;
  logic [4:0]       step;
  logic [3:0]       k;
  logic [4:0]       dcnt;
  logic [63:0]      nreg [NUM_NREGS];
  wide_t            wreg [NUM_WREGS];
  mac_op_t          op;
  wreg_t            rd_addr;
  nreg_t            n_addr;
  wide_t            wreg_rd, a_val, wr_base, num_v, den_v;
  logic [63:0]      n_rd;
  wide_t            mag_a, tmp, rem, trial, dmag;
  logic [63:0]      mag_b, prod;
  logic [3:0]       poff;
  logic             pv, sign_a, mneg, qneg, sing;
  logic [FIT_W-1:0] qv, fit, lim, qc;
  logic signed [31:0] tsq;

  assign op      = prog_step(step);
  assign rd_addr = (state == S_LDA) ? op.a_w : op.dst;
  assign n_addr  = (state == S_LDA) ? op.a_n : op.b_n;
  assign wreg_rd = wreg[rd_addr];
  assign n_rd    = nreg[n_addr];
  assign a_val   = op.a_wide ? wreg_rd : {{(WIDE_W-64){n_rd[63]}}, n_rd};
  assign wr_base = op.clr ? '0 : wreg_rd;
  assign num_v   = wreg[W_NUM];
  assign den_v   = wreg[W_DET];
  assign tsq     = target * target;
  assign lim     = qneg ? {1'b1, {(FIT_W-1){1'b0}}} : {1'b0, {(FIT_W-1){1'b1}}};
  assign qc      = (qv > lim) ? lim : qv;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (start) state_next = run ? S_LDA : S_DONE;
      S_LDA:   state_next = S_LDB;
      S_LDB:   state_next = S_MUL;
      S_MUL:   if (k == 4'hF) state_next = S_DRAIN;
      S_DRAIN: state_next = S_WR;
      S_WR: begin
        if (step == 5'(DET_LAST)) begin
          state_next = S_CHECK;
        end else if (step == 5'(PROG_LEN - 1)) begin
          state_next = S_DIV0;
        end else begin
          state_next = S_LDA;
        end
      end
      S_CHECK: state_next = (den_v == '0) ? S_DONE : S_LDA;
      S_DIV0:  state_next = S_DIV1;
      S_DIV1:  state_next = S_DIV2;
      S_DIV2:  state_next = (rem >= (trial << 1)) ? S_FIN : S_DIV;
      S_DIV:   if (dcnt == 5'd0) state_next = S_FIN;
      S_FIN:   state_next = S_DONE;
      S_DONE:  if (take) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    stat.idle     = (state == S_IDLE);
    stat.done     = (state == S_DONE);
    stat.singular = sing;
    stat.fit      = fit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pv    <= 1'b0;
    end else begin
      state <= state_next;
      pv    <= (state == S_MUL);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          nreg[N_S0] <= sums.pw[0];
          nreg[N_S1] <= sums.pw[1];
          nreg[N_S2] <= sums.pw[2];
          nreg[N_S3] <= sums.pw[3];
          nreg[N_S4] <= sums.pw[4];
          nreg[N_C0] <= sums.cr[0];
          nreg[N_C1] <= sums.cr[1];
          nreg[N_C2] <= sums.cr[2];
          nreg[N_T0] <= 64'd1;
          nreg[N_T1] <= {{48{target[15]}}, target};
          nreg[N_T2] <= {{32{tsq[31]}}, tsq};
          step <= 5'd0;
          fit  <= '0;
          sing <= 1'b1;
        end
      end
      S_LDA: begin
        sign_a <= a_val[WIDE_W-1];
        mag_a  <= a_val[WIDE_W-1] ? (~a_val + wide_t'(1)) : a_val;
      end
      S_LDB: begin
        mneg  <= sign_a ^ n_rd[63] ^ op.sub;
        mag_b <= n_rd[63] ? (~n_rd + 64'd1) : n_rd;
        tmp   <= '0;
        k     <= 4'd0;
      end
      S_MUL: begin
        prod <= 64'(mag_a[LIMB_W*k[2:0] +: LIMB_W]) * 64'(mag_b[LIMB_W*k[3] +: LIMB_W]);
        poff <= {1'b0, k[2:0]} + {3'b0, k[3]};
        k    <= k + 4'd1;
        if (pv) tmp <= tmp + (wide_t'(prod) << (LIMB_W * poff));
      end
      S_DRAIN: begin
        if (pv) tmp <= tmp + (wide_t'(prod) << (LIMB_W * poff));
      end
      S_WR: begin
        wreg[op.dst] <= wr_base + (tmp ^ {WIDE_W{mneg}}) + wide_t'(mneg);
        step         <= step + 5'd1;
      end
      S_DIV0: begin
        rem  <= num_v[WIDE_W-1] ? (~num_v + wide_t'(1)) : num_v;
        dmag <= den_v[WIDE_W-1] ? (~den_v + wide_t'(1)) : den_v;
        qneg <= num_v[WIDE_W-1] ^ den_v[WIDE_W-1];
        sing <= 1'b0;
      end
      S_DIV1: begin
        // Q24.8 scaling and half-away rounding: (2*256*|n| + |d|) / (2*|d|).
        rem   <= (rem << 9) + dmag;
        trial <= dmag << LIMB_W;
        qv    <= '0;
        dcnt  <= 5'(LIMB_W - 1);
      end
      S_DIV2: begin
        if (rem >= (trial << 1)) qv <= '1;
      end
      S_DIV: begin
        if (rem >= trial) begin
          rem      <= rem - trial;
          qv[dcnt] <= 1'b1;
        end
        trial <= trial >> 1;
        dcnt  <= dcnt - 5'd1;
      end
      S_FIN: begin
        fit <= qneg ? (~qc + 32'd1) : qc;
      end
      default: begin
      end
    endcase
  end

endmodule

### hw/rtl/sqf_merge.sv
// ----------------------------------------------------------------------------
// Shifted quadratic fit merge stage
// Joins the two lane results into one output request and holds it in the
// output register until the receiver takes it.
// ----------------------------------------------------------------------------
module sqf_merge (
  input  logic                clk,
  input  logic                rst,
  input  sqf_pkg::lane_stat_t pos_stat,
  input  sqf_pkg::lane_stat_t neg_stat,
  output logic                take,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [63:0]         m_axis_tdata,  // fit_pos, fit_neg
  output logic [1:0]          m_axis_tuser   // pos_singular, neg_singular
);
  import sqf_pkg::*;

  assign take = pos_stat.done && neg_stat.done && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_axis_tdata <= {neg_stat.fit, pos_stat.fit};
      m_axis_tuser <= {neg_stat.singular, pos_stat.singular};
    end
  end

endmodule

### hw/rtl/shifted_quadratic_least_squares_fit.sv
// ----------------------------------------------------------------------------
// Shifted quadratic least-squares fit
// Per pixel, fits a quadratic to the positive and the negative image side and
// evaluates both fits at a programmable target offset.
// ----------------------------------------------------------------------------
// Usage: each slave request is one offset sample of the current pixel; tlast
// marks the final sample and tuser carries the pixel mask bit, which only
// counts on that final sample. Non-final samples are taken one per cycle.
// Once a final sample is taken, tready stays low until both lanes have copied
// the sums and started their solve; the next pixel then streams in while the
// solve runs. One master request per pixel follows the final sample, after
// the start, 27 multiply-accumulate steps on the lane's 32x32 multiplier, a
// determinant check, the divide and the output register; a saturated fit
// skips the divide loop and returns sooner, a singular pixel returns after the
// determinant check, and a masked pixel skips the solve and reports singular.
// A finished result sits in the output register while the receiver stalls;
// the lanes then hold their results and the next final sample waits.
// target_offset is written through cfg_wr_en/cfg_wr_data and takes effect at
// the next solve start. Reset (rst, synchronous) clears the sums, the sample
// count, target_offset and all handshake state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module shifted_quadratic_least_squares_fit #(
  parameter int MAX_OFFSETS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // offset_ppm, shift_pos, shift_neg, value_pos, value_neg
  input  logic [79:0] s_axis_tdata,
  input  logic [0:0]  s_axis_tuser,   // pixel_valid
  input  logic        s_axis_tlast,   // last_sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // fit_pos, fit_neg
  output logic [1:0]  m_axis_tuser    // pos_singular, neg_singular
);
  import sqf_pkg::*;

  localparam int CNT_W = $clog2(MAX_OFFSETS + 1);

  logic signed [15:0] target_offset;
  logic               hold, pix_valid;
  logic [CNT_W-1:0]   cnt;
  logic               accept, acc_en, launch, take;
  logic               pos_ready, neg_ready;
  logic signed [15:0] offset_ppm, shift_pos, shift_neg;
  logic signed [16:0] x_pos, x_neg;
  sums_t              pos_sums, neg_sums;
  lane_stat_t         pos_stat, neg_stat;

  assign offset_ppm = s_axis_tdata[15:0];
  assign shift_pos  = s_axis_tdata[31:16];
  assign shift_neg  = s_axis_tdata[47:32];

  // Abscissae before saturation; the lane accumulators clamp them.
  assign x_pos = {offset_ppm[15], offset_ppm} - {shift_pos[15], shift_pos};
  assign x_neg = {offset_ppm[15], offset_ppm} + {shift_neg[15], shift_neg};

  // After a final sample no request is taken until the solve has begun.
  assign s_axis_tready = !hold;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign acc_en        = cnt < CNT_W'(MAX_OFFSETS);

  // The sums are complete once the final sample has left the pipeline; the
  // lanes latch them and the accumulators clear in the same cycle.
  assign launch = hold && pos_ready && neg_ready && pos_stat.idle && neg_stat.idle;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_offset <= '0;
    end else if (cfg_wr_en) begin
      target_offset <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= 1'b0;
      cnt  <= '0;
    end else if (launch) begin
      hold <= 1'b0;
      cnt  <= '0;
    end else if (accept) begin
      if (s_axis_tlast) hold <= 1'b1;
      if (acc_en) cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s_axis_tlast) pix_valid <= s_axis_tuser[0];
  end

  sqf_accum u_pos_accum (
    .clk        (clk),
    .rst        (rst),
    .smp_add    (accept && acc_en),
    .smp_last   (accept && s_axis_tlast),
    .abscissa   (x_pos),
    .value      (s_axis_tdata[63:48]),
    .clear      (launch),
    .sums       (pos_sums),
    .sums_ready (pos_ready)
  );

  sqf_accum u_neg_accum (
    .clk        (clk),
    .rst        (rst),
    .smp_add    (accept && acc_en),
    .smp_last   (accept && s_axis_tlast),
    .abscissa   (x_neg),
    .value      (s_axis_tdata[79:64]),
    .clear      (launch),
    .sums       (neg_sums),
    .sums_ready (neg_ready)
  );

  sqf_solver u_pos_solver (
    .clk    (clk),
    .rst    (rst),
    .start  (launch),
    .run    (pix_valid),
    .sums   (pos_sums),
    .target (target_offset),
    .take   (take),
    .stat   (pos_stat)
  );

  sqf_solver u_neg_solver (
    .clk    (clk),
    .rst    (rst),
    .start  (launch),
    .run    (pix_valid),
    .sums   (neg_sums),
    .target (target_offset),
    .take   (take),
    .stat   (neg_stat)
  );

  sqf_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .pos_stat      (pos_stat),
    .neg_stat      (neg_stat),
    .take          (take),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // A launch hands the pixel to both lanes and reopens the input.
  a_launch_starts: assert property (@(posedge clk) disable iff (rst)
    launch |=> !hold && !pos_stat.idle && !neg_stat.idle)
    else $error("launch did not start both lanes");

  // Results leave only when both lanes have finished the same pixel.
  a_take_both: assert property (@(posedge clk) disable iff (rst)
    take |-> pos_stat.done && neg_stat.done)
    else $error("result taken from an unfinished lane");

  // The sample count never passes the configured limit.
  a_cnt_limit: assert property (@(posedge clk) disable iff (rst)
    accept && !acc_en |=> cnt == CNT_W'(MAX_OFFSETS) || !hold)
    else $error("sample count passed its limit");

endmodule

### bench/shifted_quadratic_least_squares_fit_tb.sv
// ----------------------------------------------------------------------------
// Shifted quadratic fit testbench
// Streams offset samples pixel by pixel into the fit block, predicts both
// fitted values and singular flags with exact wide arithmetic, and compares
// every result request against the prediction under random backpressure.
// ----------------------------------------------------------------------------
module shifted_quadratic_least_squares_fit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sqf_pkg::*;

  localparam int SAMPLE_CAP = 64;

  typedef logic signed [383:0] big_t;

  // One offset sample of a pixel, as it travels on the slave side.
  typedef struct {
    logic signed [15:0] offset;
    logic signed [15:0] shift_pos;
    logic signed [15:0] shift_neg;
    logic [15:0]        value_pos;
    logic [15:0]        value_neg;
    logic               pix_valid;
    logic               last;
  } sample_t;

  typedef struct {
    logic [31:0] fit_pos;
    logic [31:0] fit_neg;
    logic        pos_sing;
    logic        neg_sing;
  } fit_result_t;

  // Tracks the running sums of the pixel being streamed and keeps the fits
  // that the block owes us, oldest first.
  class fit_scoreboard;
    logic signed [15:0] target;
    logic signed [63:0] pw[2][NPOW];
    logic signed [63:0] cr[2][FIT_TERMS];
    int unsigned        taken;
    fit_result_t        owed[$];
    int                 errors;
    int                 checked;
    int                 singular_seen;

    function new();
      target = 0;
      errors = 0;
      checked = 0;
      singular_seen = 0;
      clear_pixel();
    endfunction

    function void clear_pixel();
      foreach (pw[s, k]) pw[s][k] = 0;
      foreach (cr[s, k]) cr[s][k] = 0;
      taken = 0;
    endfunction

    function logic signed [63:0] clamp64(input logic signed [129:0] v);
      logic signed [129:0] hi;
      logic signed [129:0] lo;
      hi = 64'sh7FFF_FFFF_FFFF_FFFF;
      lo = 64'sh8000_0000_0000_0000;
      if (v > hi) return hi[63:0];
      if (v < lo) return lo[63:0];
      return v[63:0];
    endfunction

    function int clamp16(input int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    // Adds x^k to the power sums and y*x^k to the cross sums, every step
    // saturating to 64 bits.
    function void add_point(input int s, input logic signed [63:0] x,
                            input logic signed [63:0] y);
      logic signed [63:0]  p;
      logic signed [129:0] a;
      logic signed [129:0] b;
      p = 1;
      for (int k = 0; k < NPOW; k++) begin
        a = pw[s][k];
        b = p;
        pw[s][k] = clamp64(a + b);
        if (k < FIT_TERMS) begin
          a = p;
          b = y;
          b = clamp64(a * b);
          a = cr[s][k];
          cr[s][k] = clamp64(a + b);
        end
        a = p;
        b = x;
        p = clamp64(a * b);
      end
    endfunction

    function big_t det3(input big_t m[3][3]);
      return m[0][0] * (m[1][1] * m[2][2] - m[1][2] * m[2][1])
           - m[0][1] * (m[1][0] * m[2][2] - m[1][2] * m[2][0])
           + m[0][2] * (m[1][0] * m[2][1] - m[1][1] * m[2][0]);
    endfunction

    // Cramer solution evaluated at the target, rounded half away from zero
    // to Q24.8 and saturated. Returns 1 when the normal matrix is singular.
    function bit solve_side(input int s, output logic [31:0] fit);
      big_t        m[3][3];
      big_t        m2[3][3];
      big_t        den;
      big_t        num;
      big_t        tp;
      logic [383:0] un;
      logic [383:0] ud;
      logic [383:0] q;
      logic [383:0] lim;
      bit          neg;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) m[i][j] = pw[s][i + j];
      den = det3(m);
      fit = '0;
      if (den == 0) return 1;
      num = 0;
      tp = 1;
      for (int k = 0; k < 3; k++) begin
        m2 = m;
        for (int i = 0; i < 3; i++) m2[i][k] = cr[s][i];
        num = num + det3(m2) * tp;
        tp = tp * target;
      end
      num = num * 256;
      neg = (num < 0) != (den < 0);
      un = (num < 0) ? -num : num;
      ud = (den < 0) ? -den : den;
      q = (2 * un + ud) / (2 * ud);
      lim = neg ? 384'h8000_0000 : 384'h7FFF_FFFF;
      if (q > lim) q = lim;
      fit = neg ? -q[31:0] : q[31:0];
      return 0;
    endfunction

    function void note_sample(input sample_t sm);
      fit_result_t r;
      int          xp;
      int          xn;
      if (taken < SAMPLE_CAP) begin
        xp = clamp16(int'(sm.offset) - int'(sm.shift_pos));
        xn = clamp16(int'(sm.offset) + int'(sm.shift_neg));
        add_point(0, xp, {48'b0, sm.value_pos});
        add_point(1, xn, {48'b0, sm.value_neg});
        taken++;
      end
      if (!sm.last) return;
      r.fit_pos = '0;
      r.fit_neg = '0;
      r.pos_sing = 1'b1;
      r.neg_sing = 1'b1;
      if (sm.pix_valid) begin
        r.pos_sing = solve_side(0, r.fit_pos);
        r.neg_sing = solve_side(1, r.fit_neg);
      end
      owed.push_back(r);
      clear_pixel();
    endfunction

    function void check_result(input logic [63:0] data, input logic [1:0] user);
      fit_result_t e;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result with no pixel pending: data=%h user=%b", data, user);
        return;
      end
      e = owed.pop_front();
      checked++;
      if (user != 2'b00) singular_seen++;
      if (data[31:0] !== e.fit_pos || data[63:32] !== e.fit_neg ||
          user[0] !== e.pos_sing || user[1] !== e.neg_sing) begin
        errors++;
        if (errors <= 10)
          $display("fit mismatch: exp pos=%h neg=%h sing=%b%b, got pos=%h neg=%h sing=%b%b",
                   e.fit_pos, e.fit_neg, e.neg_sing, e.pos_sing,
                   data[31:0], data[63:32], user[1], user[0]);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // offset_ppm, shift_pos, shift_neg, value_pos, value_neg (lowest bits first)
  logic [79:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;   // pixel_valid
  logic        s_axis_tlast = 1'b0; // last_sample
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // fit_pos, fit_neg (lowest bits first)
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;         // pos_singular, neg_singular

  shifted_quadratic_least_squares_fit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  fit_scoreboard sb = new();

  // Percent of cycles in which the sender and the receiver sit idle.
  int send_idle = 22;
  int recv_idle = 61;
  // Cycles left in a forced receiver hold-off.
  int hold_left = 0;
  int samples_sent = 0;
  int pixels_sent = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: checks each result request, then picks the next ready value.
  // The hold-off counter overrides the random stalls while it runs.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Watchdog: a long run of cycles without any request moving is a hang.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
      if (quiet >= 20000) begin
        $display("shifted_quadratic_least_squares_fit_tb: errors");
        $finish;
      end
    end
  end

  function automatic sample_t mk(input int o, input int sp, input int sn, input int vp,
                                 input int vn, input bit v, input bit l);
    sample_t sm;
    sm.offset = 16'(o);
    sm.shift_pos = 16'(sp);
    sm.shift_neg = 16'(sn);
    sm.value_pos = 16'(vp);
    sm.value_neg = 16'(vn);
    sm.pix_valid = v;
    sm.last = l;
    return sm;
  endfunction

  // Offers one sample request, with random idle cycles before it, and waits
  // for the block to take it.
  task automatic push_sample(input sample_t sm);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tdata <= {sm.value_neg, sm.value_pos, sm.shift_neg, sm.shift_pos, sm.offset};
    s_axis_tuser <= sm.pix_valid;
    s_axis_tlast <= sm.last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_sample(sm);
    samples_sent++;
    if (sm.last) pixels_sent++;
  endtask

  // Streams one pixel of n samples. Kind 0 keeps offsets and shifts moderate,
  // kind 1 uses the full field range, kind 2 repeats one abscissa so that
  // the system is singular.
  task automatic send_pixel(input int n, input bit valid, input int kind);
    sample_t sm;
    int      o;
    int      sp;
    int      sn;
    o = int'($urandom_range(8192)) - 4096;
    sp = int'($urandom_range(512)) - 256;
    sn = int'($urandom_range(512)) - 256;
    for (int i = 0; i < n; i++) begin
      if (kind == 1) begin
        o = $urandom;
        sp = $urandom;
        sn = $urandom;
      end else if (kind == 0) begin
        o = int'($urandom_range(8192)) - 4096;
        sp = int'($urandom_range(512)) - 256;
        sn = int'($urandom_range(512)) - 256;
      end
      sm = mk(o, sp, sn, $urandom, $urandom,
              (i == n - 1) ? valid : 1'($urandom_range(1)), i == n - 1);
      push_sample(sm);
    end
  endtask

  // Pauses the sender until every owed result has come back.
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
  endtask

  // Changes the target only while the block is idle: it waits for every owed
  // result, masked pixels included, and then allows time for a full solve.
  task automatic write_target(input logic signed [15:0] v);
    wait_drain();
    repeat (700) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.target = v;
  endtask

  initial begin
    logic signed [15:0] targets[6];
    int                 phase_items;
    int                 pix;
    int                 r;
    targets[0] = 16'sd1024;
    targets[1] = 16'sh7FFF;
    targets[2] = 16'sh8000;
    targets[3] = 16'($urandom);
    targets[4] = -16'sd512;
    targets[5] = 16'($urandom);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pixels at the reset target of zero: field extremes, abscissa
    // saturation, a masked pixel, a repeated abscissa, a lone sample, and a
    // pixel whose negative side collapses onto one abscissa.
    push_sample(mk(-32768, 0, 0, 0, 0, 1, 0));
    push_sample(mk(0, 0, 0, 65535, 65535, 1, 0));
    push_sample(mk(32767, 0, 0, 1234, 4321, 1, 1));
    push_sample(mk(32767, -32768, 32767, 100, 200, 0, 0));
    push_sample(mk(-32768, 32767, -32768, 65535, 0, 0, 0));
    push_sample(mk(0, 1, -1, 7, 9, 1, 1));
    push_sample(mk(-100, 5, 5, 300, 400, 1, 0));
    push_sample(mk(0, 5, 5, 500, 600, 1, 0));
    push_sample(mk(100, 5, 5, 300, 400, 0, 1));
    push_sample(mk(100, 0, 0, 1, 2, 1, 0));
    push_sample(mk(100, 0, 0, 3, 4, 1, 0));
    push_sample(mk(100, 0, 0, 5, 6, 1, 1));
    push_sample(mk(2048, 0, 0, 65535, 65535, 1, 1));
    push_sample(mk(-3000, 10, 3050, 65535, 10, 1, 0));
    push_sample(mk(-1000, -20, 1050, 0, 20, 1, 0));
    push_sample(mk(1000, 30, -950, 65535, 30, 1, 0));
    push_sample(mk(3000, -40, -2950, 0, 40, 1, 1));
    wait_drain();

    // Receiver holds off for a long stretch while pixels keep coming, so the
    // lanes fill up and the input stalls; then the sender waits for all.
    hold_left = 1500;
    for (int i = 0; i < 12; i++) send_pixel(4, 1'b1, 0);
    wait_drain();

    // Random phases: the idle mix moves from a slow receiver to a slow
    // sender to no idling, with a new target for each phase.
    for (int ph = 0; ph < 6; ph++) begin
      write_target(targets[ph]);
      case (ph / 2)
        0: begin
          send_idle = 22;
          recv_idle = 61;
        end
        1: begin
          send_idle = 61;
          recv_idle = 22;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      phase_items = samples_sent;
      pix = 0;
      while (samples_sent - phase_items < 180) begin
        r = $urandom_range(99);
        pix++;
        if (pix % 25 == 0) send_pixel($urandom_range(70, 64), 1'b1, r & 1);
        else if (r < 55) send_pixel($urandom_range(12, 3), 1'b1, 0);
        else if (r < 75) send_pixel($urandom_range(8, 3), 1'b1, 1);
        else if (r < 85) send_pixel($urandom_range(8, 1), 1'b0, 0);
        else if (r < 92) send_pixel($urandom_range(5, 2), 1'b1, 2);
        else send_pixel($urandom_range(2, 1), 1'b1, 0);
      end
    end

    wait_drain();
    repeat (700) @(posedge clk);
    $display("Streamed %0d samples in %0d pixels over seven targets; %0d fits checked.",
             samples_sent, pixels_sent, sb.checked);
    $display("Masked or singular results seen: %0d; mismatches: %0d.",
             sb.singular_seen, sb.errors);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("shifted_quadratic_least_squares_fit_tb: clean");
    end else begin
      $display("shifted_quadratic_least_squares_fit_tb: errors");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/sqf_pkg.sv
hw/rtl/sqf_accum.sv
hw/rtl/sqf_solver.sv
hw/rtl/sqf_merge.sv
hw/rtl/shifted_quadratic_least_squares_fit.sv
bench/shifted_quadratic_least_squares_fit_tb.sv
